[hdl/trps_pkg.sv]
// Shared types and constants for the timer prescaler / reload solver.
// Used by trps_divider and timer_prescaler_reload_solver_top; no dependencies.
package trps_pkg;

  // Field widths
  localparam int unsigned ClkW = 32;  // clock rate and quotient width
  localparam int unsigned PreW = 16;  // prescaler field width
  localparam int unsigned DivW = 17;  // divider counter, holds 1 .. 65537
  localparam int unsigned StepW = 5;  // division step counter, 32 steps

  // Largest reload count of the 16-bit counter
  localparam logic [ClkW-1:0] NarrowLimit = 32'h0001_0000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_WAIT  = 3'b100
  } trps_state_e;

  // Divider result bundle
  typedef struct packed {
    logic            done;
    logic [ClkW-1:0] quotient;
    logic [ClkW-1:0] remainder;
  } trps_div_rsp_t;

endpackage

[hdl/timer_prescaler_reload_solver_top.sv]
// Top level of the timer prescaler / reload solver: candidate sequencer
// around one shared serial divider. Depends on trps_pkg and trps_divider.
//
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+-----------------------
//  request  | clk_rate_i, tick_rate_i, wide_counter_i        | start high, busy low
//  result   | found_o, prescaler_o, reload_o                 | done_o, one cycle
//
// Each candidate divider takes one bound check, 32 divide steps and one result
// check. A word accepted while idle gives its result strobe once the k-th
// candidate fits, or once the search gives up after k candidates; k is at most
// MAX_DIVIDER. Reset leaves the block idle with busy low. The result strobe
// cannot be held off; busy is low in the strobe cycle.
module timer_prescaler_reload_solver_top #(
  parameter int unsigned MAX_DIVIDER = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [trps_pkg::ClkW-1:0]       clk_rate_i,
  input  logic [trps_pkg::ClkW-1:0]       tick_rate_i,
  input  logic                            wide_counter_i,
  output logic                            done_o,
  output logic                            found_o,
  output logic [trps_pkg::PreW-1:0]       prescaler_o,
  output logic [trps_pkg::ClkW-1:0]       reload_o
);

  localparam logic [trps_pkg::DivW-1:0] DivMax = trps_pkg::DivW'(MAX_DIVIDER);

  trps_pkg::trps_state_e         state_q, state_d;
  logic                          done_q, done_d;
  logic                          found_q, found_d;
  logic [trps_pkg::PreW-1:0]     pre_q, pre_d;
  logic [trps_pkg::ClkW-1:0]     rel_q, rel_d;
  logic [trps_pkg::ClkW-1:0]     clk_q, clk_d;
  logic [trps_pkg::ClkW-1:0]     freq_q, freq_d;
  logic                          wide_q, wide_d;
  logic [trps_pkg::DivW-1:0]     div_q, div_d;
  logic [trps_pkg::ClkW:0]       den_q, den_d;
  logic                          div_start;
  logic                          stop;
  logic                          exact;
  trps_pkg::trps_div_rsp_t       div_rsp;

  trps_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (clk_q),
    .divisor_i  (den_q[trps_pkg::ClkW-1:0]),
    .rsp_o      (div_rsp)
  );

  // Give up on zero frequency, a product past the clock, or no dividers left
  assign stop = (freq_q == '0) || (den_q > {1'b0, clk_q}) || (div_q > DivMax);

  // Exact quotient that fits the counter
  assign exact = (div_rsp.remainder == '0) &&
                 (wide_q || (div_rsp.quotient <= trps_pkg::NarrowLimit));

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    found_d   = found_q;
    pre_d     = pre_q;
    rel_d     = rel_q;
    clk_d     = clk_q;
    freq_d    = freq_q;
    wide_d    = wide_q;
    div_d     = div_q;
    den_d     = den_q;
    div_start = 1'b0;
    case (state_q)
      trps_pkg::ST_IDLE: begin
        // take a new word, first candidate divider is one
        if (start) begin
          clk_d   = clk_rate_i;
          freq_d  = tick_rate_i;
          wide_d  = wide_counter_i;
          div_d   = trps_pkg::DivW'(1);
          den_d   = {1'b0, tick_rate_i};
          state_d = trps_pkg::ST_CHECK;
        end
      end
      trps_pkg::ST_CHECK: begin
        if (stop) begin
          done_d  = 1'b1;
          found_d = 1'b0;
          pre_d   = '0;
          rel_d   = '0;
          state_d = trps_pkg::ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = trps_pkg::ST_WAIT;
        end
      end
      trps_pkg::ST_WAIT: begin
        if (div_rsp.done) begin
          if (exact) begin
            done_d  = 1'b1;
            found_d = 1'b1;
            pre_d   = trps_pkg::PreW'(div_q - 1'b1);
            rel_d   = div_rsp.quotient - 1'b1;
            state_d = trps_pkg::ST_IDLE;
          end else begin
            // advance to the next divider; product stays below 2^33
            div_d   = div_q + 1'b1;
            den_d   = den_q + {1'b0, freq_q};
            state_d = trps_pkg::ST_CHECK;
          end
        end
      end
      default: begin
        state_d = trps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trps_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    pre_q   <= pre_d;
    rel_q   <= rel_d;
    clk_q   <= clk_d;
    freq_q  <= freq_d;
    wide_q  <= wide_d;
    div_q   <= div_d;
    den_q   <= den_d;
  end

  assign busy        = (state_q != trps_pkg::ST_IDLE);
  assign done_o      = done_q;
  assign found_o     = found_q;
  assign prescaler_o = pre_q;
  assign reload_o    = rel_q;

  // Result word only when the sequencer has gone back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted word always makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_o)
    else $error("accepted word did not start a search");

  // A failed search reports zero fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !found_o |-> prescaler_o == '0 && reload_o == '0)
    else $error("failed search left nonzero fields");

  // The divider only reports while a candidate is pending
  a_div_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == trps_pkg::ST_WAIT)
    else $error("divider result outside wait state");

endmodule

[hdl/trps_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on trps_pkg for widths and the result struct.
module trps_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [trps_pkg::ClkW-1:0]           dividend_i,
  input  logic [trps_pkg::ClkW-1:0]           divisor_i,
  output trps_pkg::trps_div_rsp_t             rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [trps_pkg::StepW-1:0]    cnt_q, cnt_d;
  logic [trps_pkg::ClkW-1:0]     rem_q, rem_d;
  logic [trps_pkg::ClkW-1:0]     quo_q, quo_d;
  logic [trps_pkg::ClkW-1:0]     dvs_q, dvs_d;
  logic [trps_pkg::ClkW:0]       trial;
  logic [trps_pkg::ClkW:0]       diff;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_q, quo_q[trps_pkg::ClkW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      // load a fresh word
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // advance one quotient bit
      if (!diff[trps_pkg::ClkW]) begin
        rem_d = diff[trps_pkg::ClkW-1:0];
        quo_d = {quo_q[trps_pkg::ClkW-2:0], 1'b1};
      end else begin
        rem_d = trial[trps_pkg::ClkW-1:0];
        quo_d = {quo_q[trps_pkg::ClkW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  // A new word is only loaded while the unit is free
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted mid-word");

  // Completion follows the last step and leaves the unit free
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a running word");

endmodule
